### rtl/deadline_timer_queue_core_defines.svh
// Assertion macros for the deadline timer queue checker.
`ifndef DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define DTQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dtq check failed");

// Antecedent this cycle, consequent in the next cycle.
`define DTQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtq check failed");

`endif

### rtl/dtq_pkg.sv
// Types and constants shared by the deadline timer queue files.
package dtq_pkg;

  localparam int ID_W     = 4;
  localparam int MAP_W    = 1 << ID_W;
  localparam int FTIME_W  = 48;
  localparam int WAIT_W   = 31;
  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_FIRE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STS_DONE  = 3'd0,
    STS_FIRED = 3'd1,
    STS_WAIT  = 3'd2,
    STS_EMPTY = 3'd3,
    STS_ERROR = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADD_CMP,
    ST_ADD_PUT,
    ST_RM_SCAN,
    ST_QRY,
    ST_FI_SCAN,
    ST_FI_SHIFT,
    ST_FI_FLUSH
  } state_e;

  typedef struct packed {
    op_e               opcode;
    logic [ID_W-1:0]   timer_id;
    logic [FTIME_W-1:0] deadline;
    logic [FTIME_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   fired_timer;
    logic [WAIT_W-1:0] wait_ms;
    logic              last;
  } out_item_t;

endpackage

### rtl/dtq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/deadline_timer_queue_core.sv
// Deadline timer queue: sorted timer list held in one RAM, walked one slot per cycle
// unless a stalled output holds the step. The result is valid the cycle after the
// step that makes it; a stalled output holds that step. One item at a time; the RAM port
// sets the pace. Reset clears the count, the pending map and the control state; the RAM
// is not cleared, only slots below the count are read.
module deadline_timer_queue_core #(
  parameter int TIMER_SLOTS = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dtq_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dtq_pkg::out_item_t  out_item_o
);
  import dtq_pkg::*;

  localparam int ADDR_W  = $clog2(TIMER_SLOTS);
  localparam int CNT_W   = $clog2(TIMER_SLOTS + 1);
  localparam int ENTRY_W = TIME_BITS + ID_W;

  state_e                state_q, state_d;
  op_e                   op_q;
  logic [ID_W-1:0]       id_q;
  logic [TIME_BITS-1:0]  dl_q;
  logic [TIME_BITS-1:0]  now_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [MAP_W-1:0]      map_q, map_d;
  logic [ADDR_W-1:0]     ptr_q, ptr_d;
  logic [ADDR_W-1:0]     wptr_q, wptr_d;
  logic                  shift_q, shift_d;
  logic                  pend_q, pend_d;
  logic [ID_W-1:0]       pend_id_q, pend_id_d;
  out_item_t             out_q, res;
  logic                  out_valid_q;

  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;
  logic [TIME_BITS-1:0]  rd_dl;
  logic [ID_W-1:0]       rd_id;
  logic [TIME_BITS-1:0]  diff;
  logic [63:0]           diff64;
  logic [WAIT_W-1:0]     wait_val;
  logic                  last_slot;
  logic                  emit;
  logic                  out_free;
  logic                  in_accept;

  function automatic out_item_t mk_res(status_e sts, logic [ID_W-1:0] fid,
                                       logic [WAIT_W-1:0] w, logic lst);
    out_item_t r;
    r.status      = sts;
    r.fired_timer = fid;
    r.wait_ms     = w;
    r.last        = lst;
    return r;
  endfunction

  // Writes and reads in one cycle never hit the same slot, so no forwarding.
  dtq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TIMER_SLOTS)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_dl     = ram_rdata[ENTRY_W-1:ID_W];
  assign rd_id     = ram_rdata[ID_W-1:0];
  assign last_slot = (CNT_W'(ptr_q) + CNT_W'(1)) == count_q;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Head deadline is the read data of slot 0 while in ST_QRY.
  assign diff   = rd_dl - now_q;
  assign diff64 = 64'(diff);
  always_comb begin
    if (now_q >= rd_dl) begin
      wait_val = '0;
    end else if (diff64 > 64'(WAIT_MAX)) begin
      wait_val = WAIT_MAX;
    end else begin
      wait_val = WAIT_W'(diff64);
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    map_d     = map_q;
    ptr_d     = ptr_q;
    wptr_d    = wptr_q;
    shift_d   = shift_q;
    pend_d    = pend_q;
    pend_id_d = pend_id_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = '0;
    ram_raddr = '0;
    ram_wdata = {dl_q, id_q};
    emit      = 1'b0;
    res       = mk_res(STS_DONE, '0, '0, 1'b1);

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        case (op_q)
          OP_ADD: begin
            if (map_q[id_q] || count_q >= CNT_W'(TIMER_SLOTS)) begin
              emit    = 1'b1;
              res     = mk_res(STS_ERROR, '0, '0, 1'b1);
              state_d = ST_IDLE;
            end else if (count_q == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              count_d   = count_q + CNT_W'(1);
              map_d     = map_q | (MAP_W'(1) << id_q);
              emit      = 1'b1;
              state_d   = ST_IDLE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = ADDR_W'(count_q - CNT_W'(1));
              ptr_d     = ADDR_W'(count_q);
              state_d   = ST_ADD_CMP;
            end
          end
          OP_REMOVE: begin
            if (!map_q[id_q]) begin
              emit    = 1'b1;
              res     = mk_res(STS_ERROR, '0, '0, 1'b1);
              state_d = ST_IDLE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              ptr_d     = '0;
              shift_d   = 1'b0;
              state_d   = ST_RM_SCAN;
            end
          end
          OP_QUERY: begin
            if (count_q == '0) begin
              emit    = 1'b1;
              res     = mk_res(STS_EMPTY, '0, '0, 1'b1);
              state_d = ST_IDLE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_d   = ST_QRY;
            end
          end
          OP_FIRE: begin
            if (count_q == '0) begin
              emit    = 1'b1;
              res     = mk_res(STS_EMPTY, '0, '0, 1'b1);
              state_d = ST_IDLE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              ptr_d     = '0;
              pend_d    = 1'b0;
              state_d   = ST_FI_SCAN;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end

      // Read data holds slot ptr-1; later deadlines move up one slot.
      ST_ADD_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        if (rd_dl > dl_q) begin
          ram_wdata = ram_rdata;
          ptr_d     = ptr_q - ADDR_W'(1);
          if (ptr_q == ADDR_W'(1)) begin
            state_d = ST_ADD_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_q - ADDR_W'(2);
          end
        end else begin
          count_d = count_q + CNT_W'(1);
          map_d   = map_q | (MAP_W'(1) << id_q);
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_ADD_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        count_d   = count_q + CNT_W'(1);
        map_d     = map_q | (MAP_W'(1) << id_q);
        emit      = 1'b1;
        state_d   = ST_IDLE;
      end

      ST_RM_SCAN: begin
        if (shift_q) begin
          ram_we    = 1'b1;
          ram_waddr = ptr_q - ADDR_W'(1);
          ram_wdata = ram_rdata;
        end else if (rd_id == id_q) begin
          shift_d = 1'b1;
        end
        if (last_slot) begin
          count_d = count_q - CNT_W'(1);
          map_d   = map_q & ~(MAP_W'(1) << id_q);
          emit    = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q + ADDR_W'(1);
          ptr_d     = ptr_q + ADDR_W'(1);
        end
      end

      ST_QRY: begin
        emit    = 1'b1;
        res     = mk_res(STS_WAIT, '0, wait_val, 1'b1);
        state_d = ST_IDLE;
      end

      // An expired id is held back one slot until its last flag is known.
      ST_FI_SCAN: begin
        if (rd_dl <= now_q) begin
          if (pend_q) begin
            emit = 1'b1;
            res  = mk_res(STS_FIRED, pend_id_q, '0, 1'b0);
          end
          pend_d    = 1'b1;
          pend_id_d = rd_id;
          map_d     = map_q & ~(MAP_W'(1) << rd_id);
          if (last_slot) begin
            state_d = ST_FI_FLUSH;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_q + ADDR_W'(1);
            ptr_d     = ptr_q + ADDR_W'(1);
          end
        end else if (!pend_q) begin
          emit    = 1'b1;
          res     = mk_res(STS_EMPTY, '0, '0, 1'b1);
          state_d = ST_IDLE;
        end else begin
          emit      = 1'b1;
          res       = mk_res(STS_FIRED, pend_id_q, '0, 1'b1);
          pend_d    = 1'b0;
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = ram_rdata;
          if (last_slot) begin
            count_d = CNT_W'(1);
            state_d = ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_q + ADDR_W'(1);
            ptr_d     = ptr_q + ADDR_W'(1);
            wptr_d    = ADDR_W'(1);
            state_d   = ST_FI_SHIFT;
          end
        end
      end

      ST_FI_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = wptr_q;
        ram_wdata = ram_rdata;
        wptr_d    = wptr_q + ADDR_W'(1);
        if (last_slot) begin
          count_d = CNT_W'(wptr_q) + CNT_W'(1);
          state_d = ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q + ADDR_W'(1);
          ptr_d     = ptr_q + ADDR_W'(1);
        end
      end

      ST_FI_FLUSH: begin
        emit    = 1'b1;
        res     = mk_res(STS_FIRED, pend_id_q, '0, 1'b1);
        pend_d  = 1'b0;
        count_d = '0;
        state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase

    // Output register busy: hold the whole step.
    if (emit && !out_free) begin
      state_d   = state_q;
      count_d   = count_q;
      map_d     = map_q;
      ptr_d     = ptr_q;
      wptr_d    = wptr_q;
      shift_d   = shift_q;
      pend_d    = pend_q;
      pend_id_d = pend_id_q;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      emit      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      map_q       <= '0;
      ptr_q       <= '0;
      wptr_q      <= '0;
      shift_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      map_q   <= map_d;
      ptr_q   <= ptr_d;
      wptr_q  <= wptr_d;
      shift_q <= shift_d;
      pend_q  <= pend_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
    if (in_accept) begin
      op_q  <= in_item_i.opcode;
      id_q  <= in_item_i.timer_id;
      dl_q  <= TIME_BITS'(in_item_i.deadline);
      now_q <= TIME_BITS'(in_item_i.now_time);
    end
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### rtl/dtq_checker.sv
// Port-level checks for the deadline timer queue, bound to the top level.
`include "deadline_timer_queue_core_defines.svh"

module dtq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input dtq_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input dtq_pkg::out_item_t out_item_o
);
  import dtq_pkg::*;

  logic in_acc;
  assign in_acc  = in_valid_i && !in_stall_o;

  `DTQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))
  `DTQ_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, in_stall_o)
  `DTQ_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o, $stable(in_item_i))
  `DTQ_ASSERT(a_single_is_last, clk_i, rst_ni, out_valid_o && out_item_o.status != STS_FIRED |-> out_item_o.last)
  `DTQ_ASSERT(a_wait_only_on_wait, clk_i, rst_ni, out_valid_o && out_item_o.status != STS_WAIT |-> out_item_o.wait_ms == '0)

endmodule

bind deadline_timer_queue_core dtq_checker u_dtq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

### tb/tb_top.sv
// Self-checking testbench for the deadline timer queue core.
`timescale 1ns / 1ps

module tb_top;
  import dtq_pkg::*;

  localparam int SLOTS = 16;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      out_stall_i = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  // Predicted queue contents
  logic [FTIME_W-1:0] tq_dl [SLOTS];
  logic [ID_W-1:0]    tq_id [SLOTS];
  int                 tq_cnt = 0;
  logic [MAP_W-1:0]   tq_map = '0;

  out_item_t outcome_q[$];
  out_item_t head;
  int        mismatches = 0;
  int        items_in;
  logic [FTIME_W-1:0] sim_now = 48'd1000;

  deadline_timer_queue_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [FTIME_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[FTIME_W-1:0];
  endfunction

  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < tq_cnt; i++) begin
      tq_dl[i] = tq_dl[i+1];
      tq_id[i] = tq_id[i+1];
    end
    tq_cnt--;
  endfunction

  function automatic void apply_timer_op(in_item_t it);
    out_item_t          r;
    int                 pos;
    bit                 fired;
    logic [FTIME_W-1:0] w;
    r = '0;
    r.last = 1'b1;
    case (it.opcode)
      OP_ADD: begin
        if (tq_map[it.timer_id] || tq_cnt >= SLOTS) begin
          r.status = STS_ERROR;
        end else begin
          pos = 0;
          while (pos < tq_cnt && tq_dl[pos] <= it.deadline) pos++;
          for (int i = tq_cnt; i > pos; i--) begin
            tq_dl[i] = tq_dl[i-1];
            tq_id[i] = tq_id[i-1];
          end
          tq_dl[pos] = it.deadline;
          tq_id[pos] = it.timer_id;
          tq_cnt++;
          tq_map[it.timer_id] = 1'b1;
          r.status = STS_DONE;
        end
        outcome_q.push_back(r);
      end
      OP_REMOVE: begin
        if (!tq_map[it.timer_id]) begin
          r.status = STS_ERROR;
        end else begin
          for (pos = 0; pos < tq_cnt; pos++) begin
            if (tq_id[pos] == it.timer_id) break;
          end
          drop_slot(pos);
          tq_map[it.timer_id] = 1'b0;
          r.status = STS_DONE;
        end
        outcome_q.push_back(r);
      end
      OP_QUERY: begin
        if (tq_cnt == 0) begin
          r.status = STS_EMPTY;
        end else begin
          w = (it.now_time >= tq_dl[0]) ? '0 : tq_dl[0] - it.now_time;
          r.status  = STS_WAIT;
          r.wait_ms = (w > FTIME_W'(WAIT_MAX)) ? WAIT_MAX : w[WAIT_W-1:0];
        end
        outcome_q.push_back(r);
      end
      default: begin
        fired = 1'b0;
        while (tq_cnt > 0 && tq_dl[0] <= it.now_time) begin
          r = '0;
          r.status      = STS_FIRED;
          r.fired_timer = tq_id[0];
          tq_map[tq_id[0]] = 1'b0;
          drop_slot(0);
          r.last = !(tq_cnt > 0 && tq_dl[0] <= it.now_time);
          outcome_q.push_back(r);
          fired = 1'b1;
        end
        if (!fired) begin
          r = '0;
          r.status = STS_EMPTY;
          r.last   = 1'b1;
          outcome_q.push_back(r);
        end
      end
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_id(bit want_pending);
    logic [ID_W-1:0] start;
    logic [ID_W-1:0] id;
    start = ID_W'($urandom_range(MAP_W - 1));
    for (int k = 0; k < MAP_W; k++) begin
      id = start + ID_W'(k);
      if (tq_map[id] == want_pending) return id;
    end
    return start;
  endfunction

  function automatic stim_row_t mk_row(op_e op, int id, logic [FTIME_W-1:0] dl,
                                       logic [FTIME_W-1:0] now_t, bit typed,
                                       status_e sts, logic [WAIT_W-1:0] w);
    stim_row_t row;
    row.item.opcode   = op;
    row.item.timer_id = ID_W'(id);
    row.item.deadline = dl;
    row.item.now_time = now_t;
    row.typed         = typed;
    row.want          = '0;
    row.want.status   = sts;
    row.want.wait_ms  = w;
    row.want.last     = 1'b1;
    return row;
  endfunction

  function automatic bit calm_stretch();
    return items_in >= 230 && items_in < 320;
  endfunction

  task automatic offer_item(input in_item_t it, input bit typed, input out_item_t want);
    while (!calm_stretch() && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    apply_timer_op(it);
    if (typed) begin
      void'(outcome_q.pop_back());
      outcome_q.push_back(want);
    end
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      items_in <= 0;
    end else if (in_valid_i && !in_stall_o) begin
      items_in <= items_in + 1;
    end
  end

  // Receiver: random stall, one long hold-off, a calm stretch
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && items_in >= 120) begin
        held = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (calm_stretch()) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 37);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (outcome_q.size() == 0) begin
        $error("unexpected result: status %0d id %0d wait %0d last %0d",
               out_item_o.status, out_item_o.fired_timer, out_item_o.wait_ms,
               out_item_o.last);
        mismatches++;
      end else begin
        head = outcome_q.pop_front();
        if (out_item_o.status !== head.status) begin
          $error("status: expected %0d, got %0d", head.status, out_item_o.status);
          mismatches++;
        end
        if (out_item_o.fired_timer !== head.fired_timer) begin
          $error("fired_timer: expected %0d, got %0d", head.fired_timer,
                 out_item_o.fired_timer);
          mismatches++;
        end
        if (out_item_o.wait_ms !== head.wait_ms) begin
          $error("wait_ms: expected %0d, got %0d", head.wait_ms, out_item_o.wait_ms);
          mismatches++;
        end
        if (out_item_o.last !== head.last) begin
          $error("last: expected %0d, got %0d", head.last, out_item_o.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    stim_row_t          rows[$];
    in_item_t           it;
    logic [FTIME_W-1:0] tmax;
    int                 ph;
    int                 roll;
    int                 add_t;
    int                 rm_t;
    int                 q_t;
    int                 mode;
    tmax = '1;

    // empty queue, idle remove, far deadline, duplicate add
    rows.push_back(mk_row(OP_QUERY,  0, '0, '0, 1'b1, STS_EMPTY, '0));
    rows.push_back(mk_row(OP_FIRE,  15, tmax, tmax, 1'b1, STS_EMPTY, '0));
    rows.push_back(mk_row(OP_REMOVE, 5, '0, '0, 1'b1, STS_ERROR, '0));
    rows.push_back(mk_row(OP_ADD,   15, tmax, '0, 1'b1, STS_DONE, '0));
    rows.push_back(mk_row(OP_QUERY,  0, '0, '0, 1'b1, STS_WAIT, WAIT_MAX));
    rows.push_back(mk_row(OP_ADD,   15, '0, tmax, 1'b1, STS_ERROR, '0));
    // fill with tied deadlines
    for (int k = 0; k < 15; k++) begin
      rows.push_back(mk_row(OP_ADD, k, FTIME_W'(k % 5) * 48'd500, tmax, 1'b1,
                            STS_DONE, '0));
    end
    rows.push_back(mk_row(OP_ADD,    9, 48'd1, '0, 1'b1, STS_ERROR, '0));
    rows.push_back(mk_row(OP_QUERY,  0, '0, tmax, 1'b1, STS_WAIT, '0));
    rows.push_back(mk_row(OP_FIRE,   0, '0, tmax, 1'b0, STS_DONE, '0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) offer_item(rows[r].item, rows[r].typed, rows[r].want);

    for (int i = 0; i < 500; i++) begin
      ph   = (i / 40) % 3;
      roll = $urandom_range(99);
      case (ph)
        0: begin add_t = 40; rm_t = 60; q_t = 75; end
        1: begin add_t = 75; rm_t = 83; q_t = 93; end
        default: begin add_t = 25; rm_t = 40; q_t = 55; end
      endcase
      it.timer_id = ID_W'($urandom_range(MAP_W - 1));
      it.deadline = rand_time();
      it.now_time = rand_time();
      if (roll < add_t) begin
        it.opcode = OP_ADD;
        if ($urandom_range(99) < 85) it.timer_id = pick_id(1'b0);
        mode = $urandom_range(9);
        if (mode == 1 && tq_cnt > 0) begin
          it.deadline = tq_dl[$urandom_range(tq_cnt - 1)];
        end else if (mode == 2) begin
          it.deadline = sim_now - FTIME_W'($urandom_range(300));
        end else if (mode > 2) begin
          it.deadline = sim_now + FTIME_W'($urandom_range(400));
        end
      end else if (roll < rm_t) begin
        it.opcode = OP_REMOVE;
        if ($urandom_range(99) < 80) it.timer_id = pick_id(1'b1);
      end else if (roll < q_t) begin
        it.opcode = OP_QUERY;
        if ($urandom_range(99) < 85) it.now_time = sim_now;
      end else begin
        it.opcode = OP_FIRE;
        sim_now = sim_now + FTIME_W'($urandom_range(200));
        if ($urandom_range(99) < 90) it.now_time = sim_now;
      end
      offer_item(it, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
